// ----- src/tbg_pkg.sv -----
package tbg_pkg;

    localparam int COORD_WIDTH = 32;
    // Coordinate width actually used, held to 16..32
    localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);

    localparam int LIMB = 32;              // multiplier slice width
    localparam int OUT_W = 32;             // port width of forces
    localparam int DW = CW + 1;            // |delta| width
    localparam int SQW = 2 * CW + 1;       // delta squared
    localparam int SW = 2 * CW + 2;        // squared distance
    localparam int MW = 2 * LIMB;          // mass product
    localparam int NPW = MW + CW;          // mass product times |delta|
    localparam int SQRT_SHIFT = 62;
    localparam int NUM_SHIFT = 47;
    localparam int RW = (SW + SQRT_SHIFT + 1) / 2;   // root width
    localparam int AW = 2 * RW;                      // radicand width
    localparam int DENW = SW + RW;                   // denominator width
    localparam int NW = NPW + NUM_SHIFT;             // numerator width
    localparam int QW = 81;                          // quotient bits (quotient < 2^80)
    localparam int FW = QW + 1;                      // signed pair force
    localparam int SUMW = QW + 2;                    // signed resultant before clamp
    localparam int SPAD = 3 * LIMB;                  // squared distance, sliced
    localparam int RPAD = 2 * LIMB;                  // root, sliced
    localparam int SL = SPAD / LIMB;
    localparam int RL = RPAD / LIMB;
    localparam int CPW = SPAD + LIMB;                // one column of partial products
    localparam int DPW = SPAD + RPAD;                // full product
    localparam int FRONT_STG = 3;
    localparam int DEN_STG = 3;
    localparam int LAT = FRONT_STG + RW + DEN_STG + QW + 1;

    typedef struct packed {
        logic [SW-1:0]  s;
        logic [NPW-1:0] nx;
        logic [NPW-1:0] ny;
        logic           negx;
        logic           negy;
        logic           coin;
    } root_side_t;

    typedef struct packed {
        logic negx;
        logic negy;
        logic coin;
    } sign_side_t;

    typedef struct packed {
        logic signed [FW-1:0] fx;
        logic signed [FW-1:0] fy;
        logic                 coin;
    } pair_force_t;

    function automatic logic signed [OUT_W-1:0] sat_force(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        logic signed [CW-1:0]   r;
        hi = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};
        if (v > hi)
        begin
            r = hi[CW-1:0];
        end
        else if (v < lo)
        begin
            r = lo[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return OUT_W'(r);
    endfunction

endpackage

// ----- src/tbg_isqrt.sv -----
// One root bit per stage, restoring digit recurrence.
module tbg_isqrt (
    input  logic                clk,
    input  logic                adv,
    input  tbg_pkg::root_side_t side_in,
    output logic [tbg_pkg::RW-1:0] root,
    output tbg_pkg::root_side_t side_out
);
    localparam int RW = tbg_pkg::RW;
    localparam int AW = tbg_pkg::AW;
    localparam int SQRT_SHIFT = tbg_pkg::SQRT_SHIFT;

    logic [RW+1:0]       rem_reg  [RW];
    logic [RW-1:0]       root_reg [RW];
    logic [AW-1:0]       a_reg    [RW];
    tbg_pkg::root_side_t side_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [RW+1:0]       rem_in;
        logic [RW-1:0]       root_in;
        logic [AW-1:0]       a_in;
        tbg_pkg::root_side_t sd_in;
        logic [RW+3:0]       t;
        logic [RW+3:0]       trial;
        logic [RW+3:0]       diff;
        logic                ge;
        logic [RW+1:0]       rem_next;
        logic [RW-1:0]       root_next;
        logic [AW-1:0]       a_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign a_in    = AW'({side_in.s, {SQRT_SHIFT{1'b0}}});
            assign sd_in   = side_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign a_in    = a_reg[k-1];
            assign sd_in   = side_reg[k-1];
        end

        always_comb
        begin
            t         = {rem_in, a_in[AW-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            diff      = t - trial;
            ge        = (t >= trial);
            rem_next  = ge ? diff[RW+1:0] : t[RW+1:0];
            root_next = {root_in[RW-2:0], ge};
            a_next    = a_in << 2;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                a_reg[k]    <= a_next;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

// ----- src/tbg_div.sv -----
// Two restoring long divisions over one shared denominator, one quotient bit per stage.
module tbg_div (
    input  logic                    clk,
    input  logic                    adv,
    input  logic [tbg_pkg::NPW-1:0]  nx,
    input  logic [tbg_pkg::NPW-1:0]  ny,
    input  logic [tbg_pkg::DENW-1:0] den,
    input  tbg_pkg::sign_side_t      side_in,
    output logic [tbg_pkg::QW-1:0]   qx,
    output logic [tbg_pkg::QW-1:0]   qy,
    output tbg_pkg::sign_side_t      side_out
);
    localparam int QW = tbg_pkg::QW;
    localparam int NW = tbg_pkg::NW;
    localparam int DENW = tbg_pkg::DENW;
    localparam int NUM_SHIFT = tbg_pkg::NUM_SHIFT;

    logic [NW-1:0] numx;
    logic [NW-1:0] numy;

    logic [DENW-1:0]     rx_reg   [QW];
    logic [DENW-1:0]     ry_reg   [QW];
    logic [QW-1:0]       lx_reg   [QW];
    logic [QW-1:0]       ly_reg   [QW];
    logic [QW-1:0]       qx_reg   [QW];
    logic [QW-1:0]       qy_reg   [QW];
    logic [DENW-1:0]     den_reg  [QW];
    tbg_pkg::sign_side_t side_reg [QW];

    assign numx = {nx, {NUM_SHIFT{1'b0}}};
    assign numy = {ny, {NUM_SHIFT{1'b0}}};

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DENW-1:0]     rx_in;
        logic [DENW-1:0]     ry_in;
        logic [QW-1:0]       lx_in;
        logic [QW-1:0]       ly_in;
        logic [QW-1:0]       qx_in;
        logic [QW-1:0]       qy_in;
        logic [DENW-1:0]     d_in;
        tbg_pkg::sign_side_t sd_in;
        logic [DENW:0]       tx;
        logic [DENW:0]       ty;
        logic [DENW:0]       dz;
        logic [DENW:0]       dfx;
        logic [DENW:0]       dfy;
        logic                gex;
        logic                gey;
        logic [DENW-1:0]     rx_next;
        logic [DENW-1:0]     ry_next;

        if (i == 0)
        begin : g_first
            assign rx_in = DENW'(numx[NW-1:QW]);
            assign ry_in = DENW'(numy[NW-1:QW]);
            assign lx_in = numx[QW-1:0];
            assign ly_in = numy[QW-1:0];
            assign qx_in = '0;
            assign qy_in = '0;
            assign d_in  = den;
            assign sd_in = side_in;
        end
        else
        begin : g_rest
            assign rx_in = rx_reg[i-1];
            assign ry_in = ry_reg[i-1];
            assign lx_in = lx_reg[i-1];
            assign ly_in = ly_reg[i-1];
            assign qx_in = qx_reg[i-1];
            assign qy_in = qy_reg[i-1];
            assign d_in  = den_reg[i-1];
            assign sd_in = side_reg[i-1];
        end

        always_comb
        begin
            tx      = {rx_in, lx_in[QW-1]};
            ty      = {ry_in, ly_in[QW-1]};
            dz      = {1'b0, d_in};
            dfx     = tx - dz;
            dfy     = ty - dz;
            gex     = (tx >= dz);
            gey     = (ty >= dz);
            rx_next = gex ? dfx[DENW-1:0] : tx[DENW-1:0];
            ry_next = gey ? dfy[DENW-1:0] : ty[DENW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[i]   <= rx_next;
                ry_reg[i]   <= ry_next;
                lx_reg[i]   <= lx_in << 1;
                ly_reg[i]   <= ly_in << 1;
                qx_reg[i]   <= {qx_in[QW-2:0], gex};
                qy_reg[i]   <= {qy_in[QW-2:0], gey};
                den_reg[i]  <= d_in;
                side_reg[i] <= sd_in;
            end
        end
    end

    assign qx       = qx_reg[QW-1];
    assign qy       = qy_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

// ----- src/tbg_pair.sv -----
// One lane: force on body i from body j, m_i*m_j*r/|r|^3.
module tbg_pair (
    input  logic                        clk,
    input  logic                        adv,
    input  logic signed [tbg_pkg::CW-1:0] xi,
    input  logic signed [tbg_pkg::CW-1:0] yi,
    input  logic signed [tbg_pkg::CW-1:0] xj,
    input  logic signed [tbg_pkg::CW-1:0] yj,
    input  logic [31:0]                 mi,
    input  logic [31:0]                 mj,
    output tbg_pkg::pair_force_t        force_out
);
    localparam int CW = tbg_pkg::CW;
    localparam int DW = tbg_pkg::DW;
    localparam int SQW = tbg_pkg::SQW;
    localparam int SW = tbg_pkg::SW;
    localparam int MW = tbg_pkg::MW;
    localparam int NPW = tbg_pkg::NPW;
    localparam int LIMB = tbg_pkg::LIMB;
    localparam int RW = tbg_pkg::RW;
    localparam int DENW = tbg_pkg::DENW;
    localparam int QW = tbg_pkg::QW;
    localparam int FW = tbg_pkg::FW;
    localparam int SPAD = tbg_pkg::SPAD;
    localparam int RPAD = tbg_pkg::RPAD;
    localparam int SL = tbg_pkg::SL;
    localparam int RL = tbg_pkg::RL;
    localparam int CPW = tbg_pkg::CPW;
    localparam int DPW = tbg_pkg::DPW;

    // stage 1: deltas, magnitudes, mass product
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;
    logic [MW-1:0]        mm_next;

    logic          axh1_reg, ayh1_reg;
    logic [CW-1:0] axl1_reg, ayl1_reg;
    logic          negx1_reg, negy1_reg, coin1_reg;
    logic [MW-1:0] mm1_reg;

    always_comb
    begin
        dx      = DW'(xj) - DW'(xi);
        dy      = DW'(yj) - DW'(yi);
        ax      = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay      = dy[DW-1] ? DW'(-dy) : DW'(dy);
        mm_next = mi * mj;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axh1_reg  <= ax[CW];
            axl1_reg  <= ax[CW-1:0];
            ayh1_reg  <= ay[CW];
            ayl1_reg  <= ay[CW-1:0];
            negx1_reg <= dx[DW-1];
            negy1_reg <= dy[DW-1];
            coin1_reg <= (dx == '0) && (dy == '0);
            mm1_reg   <= mm_next;
        end
    end

    // stage 2: squares and sliced numerator products
    logic [2*CW-1:0]      sqxl, sqyl;
    logic [LIMB+CW-1:0]   pxl_next, pxh_next, pyl_next, pyh_next;

    logic [SQW-1:0]       sqx2_reg, sqy2_reg;
    logic [LIMB+CW-1:0]   pxl2_reg, pxh2_reg, pyl2_reg, pyh2_reg;
    logic                 axh2_reg, ayh2_reg;
    logic                 negx2_reg, negy2_reg, coin2_reg;
    logic [MW-1:0]        mm2_reg;

    always_comb
    begin
        sqxl     = axl1_reg * axl1_reg;
        sqyl     = ayl1_reg * ayl1_reg;
        pxl_next = mm1_reg[LIMB-1:0] * axl1_reg;
        pxh_next = mm1_reg[MW-1:LIMB] * axl1_reg;
        pyl_next = mm1_reg[LIMB-1:0] * ayl1_reg;
        pyh_next = mm1_reg[MW-1:LIMB] * ayl1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // a magnitude of exactly 2^CW has zero low bits
            sqx2_reg  <= axh1_reg ? (SQW'(1) << (2 * CW)) : SQW'(sqxl);
            sqy2_reg  <= ayh1_reg ? (SQW'(1) << (2 * CW)) : SQW'(sqyl);
            pxl2_reg  <= pxl_next;
            pxh2_reg  <= pxh_next;
            pyl2_reg  <= pyl_next;
            pyh2_reg  <= pyh_next;
            axh2_reg  <= axh1_reg;
            ayh2_reg  <= ayh1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            coin2_reg <= coin1_reg;
            mm2_reg   <= mm1_reg;
        end
    end

    // stage 3: squared distance and full numerators
    tbg_pkg::root_side_t side3_next;
    tbg_pkg::root_side_t side3_reg;

    always_comb
    begin
        side3_next.s    = SW'(sqx2_reg) + SW'(sqy2_reg);
        side3_next.nx   = axh2_reg ? (NPW'(mm2_reg) << CW)
                                   : (NPW'(pxl2_reg) + (NPW'(pxh2_reg) << LIMB));
        side3_next.ny   = ayh2_reg ? (NPW'(mm2_reg) << CW)
                                   : (NPW'(pyl2_reg) + (NPW'(pyh2_reg) << LIMB));
        side3_next.negx = negx2_reg;
        side3_next.negy = negy2_reg;
        side3_next.coin = coin2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side3_reg <= side3_next;
        end
    end

    logic [RW-1:0]       root;
    tbg_pkg::root_side_t side_r;

    tbg_isqrt u_isqrt (
        .clk      (clk),
        .adv      (adv),
        .side_in  (side3_reg),
        .root     (root),
        .side_out (side_r)
    );

    // denominator S*R over three stages: slices, columns, total
    logic [SPAD-1:0]     sp;
    logic [RPAD-1:0]     rp;
    logic [MW-1:0]       p_next [SL][RL];
    logic [MW-1:0]       p_reg  [SL][RL];
    tbg_pkg::root_side_t side_d1_reg;

    always_comb
    begin
        sp = SPAD'(side_r.s);
        rp = RPAD'(root);
        for (int i = 0; i < SL; i++)
        begin
            for (int j = 0; j < RL; j++)
            begin
                p_next[i][j] = sp[LIMB*i +: LIMB] * rp[LIMB*j +: LIMB];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg       <= p_next;
            side_d1_reg <= side_r;
        end
    end

    logic [CPW-1:0]      c_next [RL];
    logic [CPW-1:0]      c_reg  [RL];
    tbg_pkg::root_side_t side_d2_reg;

    always_comb
    begin
        for (int j = 0; j < RL; j++)
        begin
            c_next[j] = '0;
            for (int i = 0; i < SL; i++)
            begin
                c_next[j] = c_next[j] + (CPW'(p_reg[i][j]) << (LIMB * i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg       <= c_next;
            side_d2_reg <= side_d1_reg;
        end
    end

    logic [DPW-1:0]      den_full;
    logic [DENW-1:0]     den_reg;
    tbg_pkg::sign_side_t side_d3_reg;

    always_comb
    begin
        den_full = '0;
        for (int j = 0; j < RL; j++)
        begin
            den_full = den_full + (DPW'(c_reg[j]) << (LIMB * j));
        end
    end

    logic [NPW-1:0] nx3_reg;
    logic [NPW-1:0] ny3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg          <= den_full[DENW-1:0];
            nx3_reg          <= side_d2_reg.nx;
            ny3_reg          <= side_d2_reg.ny;
            side_d3_reg.negx <= side_d2_reg.negx;
            side_d3_reg.negy <= side_d2_reg.negy;
            side_d3_reg.coin <= side_d2_reg.coin;
        end
    end

    logic [QW-1:0]       qx;
    logic [QW-1:0]       qy;
    tbg_pkg::sign_side_t side_q;

    tbg_div u_div (
        .clk      (clk),
        .adv      (adv),
        .nx       (nx3_reg),
        .ny       (ny3_reg),
        .den      (den_reg),
        .side_in  (side_d3_reg),
        .qx       (qx),
        .qy       (qy),
        .side_out (side_q)
    );

    // apply sign; a coincident pair gives no force
    logic signed [FW-1:0] fx_mag;
    logic signed [FW-1:0] fy_mag;
    tbg_pkg::pair_force_t force_next;
    tbg_pkg::pair_force_t force_reg;

    always_comb
    begin
        fx_mag          = $signed({1'b0, qx});
        fy_mag          = $signed({1'b0, qy});
        force_next.fx   = side_q.coin ? '0 : (side_q.negx ? -fx_mag : fx_mag);
        force_next.fy   = side_q.coin ? '0 : (side_q.negy ? -fy_mag : fy_mag);
        force_next.coin = side_q.coin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            force_reg <= force_next;
        end
    end

    assign force_out = force_reg;

endmodule

// ----- src/three_body_gravity_forces_top.sv -----
// Pairwise gravity for three bodies in the plane, unit gravitational constant, signed
// Q16.16. Each request carries the three positions and masses; the result gives the
// resultant force on each body, clamped to the coordinate range, and a mask of pairs
// found at zero distance (such a pair adds no force). Three identical lanes, one per
// pair, run side by side and a merging stage adds the two pair forces seen by each
// body. One request is taken every cycle while the pipeline advances; its depth is
// tbg_pkg::LAT stages, set by the lane pipeline: 3 front stages, 64 root stages (one
// root bit each), 3 stages forming the denominator, 81 divider stages (one quotient
// bit each for x and y) and a sign stage, followed by the result register. A stalled
// result holds the pipeline only once a finished request reaches its last stage;
// bubbles ahead of it keep draining, so new requests are still taken meanwhile.
module three_body_gravity_forces_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] body1_x,
    input  logic signed [31:0] body1_y,
    input  logic [31:0]        body1_mass,
    input  logic signed [31:0] body2_x,
    input  logic signed [31:0] body2_y,
    input  logic [31:0]        body2_mass,
    input  logic signed [31:0] body3_x,
    input  logic signed [31:0] body3_y,
    input  logic [31:0]        body3_mass,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] force1_x,
    output logic signed [31:0] force1_y,
    output logic signed [31:0] force2_x,
    output logic signed [31:0] force2_y,
    output logic signed [31:0] force3_x,
    output logic signed [31:0] force3_y,
    output logic [2:0]         coincident_mask
);
    localparam int CW = tbg_pkg::CW;
    localparam int LAT = tbg_pkg::LAT;
    localparam int SUMW = tbg_pkg::SUMW;

    // Pipeline control: one shared advance for every stage
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           out_load;
    logic           adv;

    // The result register can take new data when empty or being drained
    assign out_load   = !result_valid || !result_stall;
    // Advance unless a finished request sits in the last stage with nowhere to go
    assign adv        = out_load || !vld_reg[LAT-1];
    assign item_stall = !adv;

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[LAT-2:0], item_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Use only the low coordinate bits, sign-extended
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;

    assign x1 = body1_x[CW-1:0];
    assign y1 = body1_y[CW-1:0];
    assign x2 = body2_x[CW-1:0];
    assign y2 = body2_y[CW-1:0];
    assign x3 = body3_x[CW-1:0];
    assign y3 = body3_y[CW-1:0];

    tbg_pkg::pair_force_t f12, f13, f23;

    // Lanes: force on the first body of each pair from the second
    tbg_pair u_pair12 (
        .clk       (clk),
        .adv       (adv),
        .xi        (x1),
        .yi        (y1),
        .xj        (x2),
        .yj        (y2),
        .mi        (body1_mass),
        .mj        (body2_mass),
        .force_out (f12)
    );

    tbg_pair u_pair13 (
        .clk       (clk),
        .adv       (adv),
        .xi        (x1),
        .yi        (y1),
        .xj        (x3),
        .yj        (y3),
        .mi        (body1_mass),
        .mj        (body3_mass),
        .force_out (f13)
    );

    tbg_pair u_pair23 (
        .clk       (clk),
        .adv       (adv),
        .xi        (x2),
        .yi        (y2),
        .xj        (x3),
        .yj        (y3),
        .mi        (body2_mass),
        .mj        (body3_mass),
        .force_out (f23)
    );

    // Merge: the partner of each pair takes the opposite force
    logic signed [SUMW-1:0] s1x, s1y, s2x, s2y, s3x, s3y;

    always_comb
    begin
        s1x = SUMW'($signed(f12.fx)) + SUMW'($signed(f13.fx));
        s1y = SUMW'($signed(f12.fy)) + SUMW'($signed(f13.fy));
        s2x = SUMW'($signed(f23.fx)) - SUMW'($signed(f12.fx));
        s2y = SUMW'($signed(f23.fy)) - SUMW'($signed(f12.fy));
        s3x = -SUMW'($signed(f13.fx)) - SUMW'($signed(f23.fx));
        s3y = -SUMW'($signed(f13.fy)) - SUMW'($signed(f23.fy));
    end

    logic               res_vld_reg;
    logic signed [31:0] f1x_reg, f1y_reg, f2x_reg, f2y_reg, f3x_reg, f3y_reg;
    logic [2:0]         mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_vld_reg <= vld_reg[LAT-1];
        end
    end

    // Clamp each sum and hold it until taken
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            f1x_reg  <= tbg_pkg::sat_force(s1x);
            f1y_reg  <= tbg_pkg::sat_force(s1y);
            f2x_reg  <= tbg_pkg::sat_force(s2x);
            f2y_reg  <= tbg_pkg::sat_force(s2y);
            f3x_reg  <= tbg_pkg::sat_force(s3x);
            f3y_reg  <= tbg_pkg::sat_force(s3y);
            mask_reg <= {f23.coin, f13.coin, f12.coin};
        end
    end

    assign result_valid    = res_vld_reg;
    assign force1_x        = f1x_reg;
    assign force1_y        = f1y_reg;
    assign force2_x        = f2x_reg;
    assign force2_y        = f2y_reg;
    assign force3_x        = f3x_reg;
    assign force3_y        = f3y_reg;
    assign coincident_mask = mask_reg;

endmodule

// ----- verif/tb_three_body_gravity_forces_top.sv -----
module tb_three_body_gravity_forces_top;

    // One request: positions and masses of the three bodies, raw port bits
    typedef struct {
        logic [31:0] x [3];
        logic [31:0] y [3];
        logic [31:0] m [3];
    } bodies_t;

    // One result: the three resultant forces and the coincidence mask
    typedef struct {
        logic [31:0] fx [3];
        logic [31:0] fy [3];
        logic [2:0]  mask;
    } forces_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 600;
    localparam int RANDOM_REQUESTS = 1850;

    // Integer square root, one result bit per step, for radicands below 2^128
    function automatic logic [255:0] isqrt256(input logic [255:0] a);
        logic [255:0] res;
        logic [255:0] bitv;
        logic [255:0] t;
        res = '0;
        bitv = 256'd1 << 126;
        for (int k = 0; k < 64; k++)
        begin
            t = res + bitv;
            if (a >= t)
            begin
                a = a - t;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Keep the low CW bits of a coordinate and sign-extend them
    function automatic logic signed [63:0] coord(input logic [31:0] raw);
        logic signed [tbg_pkg::CW-1:0] t;
        logic signed [63:0] v;
        t = raw[tbg_pkg::CW-1:0];
        v = t;
        return v;
    endfunction

    // Force on body i from body j; returns the zero-distance flag
    function automatic logic pair_pull(input logic signed [63:0] xi, input logic signed [63:0] yi,
                                       input logic signed [63:0] xj, input logic signed [63:0] yj,
                                       input logic [31:0] mi, input logic [31:0] mj,
                                       output logic signed [255:0] fx,
                                       output logic signed [255:0] fy);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [255:0] ax;
        logic [255:0] ay;
        logic [255:0] s;
        logic [255:0] den;
        logic [255:0] mm;
        logic [255:0] qx;
        logic [255:0] qy;
        dx = xj - xi;
        dy = yj - yi;
        ax = (dx < 0) ? 256'(-dx) : 256'(dx);
        ay = (dy < 0) ? 256'(-dy) : 256'(dy);
        s = ax * ax + ay * ay;
        fx = '0;
        fy = '0;
        if (s == 0)
        begin
            return 1'b1;
        end
        den = s * isqrt256(s << 62);
        mm = (256'(mi) * 256'(mj)) << 47;
        qx = (mm * ax) / den;
        qy = (mm * ay) / den;
        fx = (dx < 0) ? -$signed(qx) : $signed(qx);
        fy = (dy < 0) ? -$signed(qy) : $signed(qy);
        return 1'b0;
    endfunction

    // Clamp an exact sum to the CW-bit signed range, written as 32 bits
    function automatic logic [31:0] clamp_force(input logic signed [255:0] v);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (tbg_pkg::CW - 1)) - 256'sd1;
        lo = -hi - 256'sd1;
        if (v > hi)
        begin
            v = hi;
        end
        else if (v < lo)
        begin
            v = lo;
        end
        return v[31:0];
    endfunction

    function automatic forces_t gravity_forces(input bodies_t b);
        logic signed [63:0] px [3];
        logic signed [63:0] py [3];
        logic signed [255:0] f12x, f12y, f13x, f13y, f23x, f23y;
        forces_t r;
        for (int i = 0; i < 3; i++)
        begin
            px[i] = coord(b.x[i]);
            py[i] = coord(b.y[i]);
        end
        r.mask[0] = pair_pull(px[0], py[0], px[1], py[1], b.m[0], b.m[1], f12x, f12y);
        r.mask[1] = pair_pull(px[0], py[0], px[2], py[2], b.m[0], b.m[2], f13x, f13y);
        r.mask[2] = pair_pull(px[1], py[1], px[2], py[2], b.m[1], b.m[2], f23x, f23y);
        // Apply the equal and opposite pair force to each partner
        r.fx[0] = clamp_force(f12x + f13x);
        r.fy[0] = clamp_force(f12y + f13y);
        r.fx[1] = clamp_force(f23x - f12x);
        r.fy[1] = clamp_force(f23y - f12y);
        r.fx[2] = clamp_force(-f13x - f23x);
        r.fy[2] = clamp_force(-f13y - f23y);
        return r;
    endfunction

    class force_scoreboard;
        forces_t pending_forces [$];
        int mismatches = 0;

        function void note_request(input bodies_t b);
            pending_forces.push_back(gravity_forces(b));
        endfunction

        function void check_result(input forces_t got);
            forces_t want;
            bit bad;
            if (pending_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: mask %0h f1 %h %h", got.mask, got.fx[0], got.fy[0]);
                return;
            end
            want = pending_forces.pop_front();
            bad = (want.mask != got.mask);
            for (int i = 0; i < 3; i++)
                bad |= (want.fx[i] != got.fx[i]) || (want.fy[i] != got.fy[i]);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp f1 %h %h f2 %h %h f3 %h %h m %0h",
                              " | got %h %h %h %h %h %h %0h"},
                             want.fx[0], want.fy[0], want.fx[1], want.fy[1], want.fx[2],
                             want.fy[2], want.mask, got.fx[0], got.fy[0], got.fx[1],
                             got.fy[1], got.fx[2], got.fy[2], got.mask);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic signed [31:0] body1_x, body1_y, body2_x, body2_y, body3_x, body3_y;
    logic [31:0] body1_mass, body2_mass, body3_mass;
    logic result_valid;
    logic result_stall;
    logic signed [31:0] force1_x, force1_y, force2_x, force2_y, force3_x, force3_y;
    logic [2:0] coincident_mask;

    force_scoreboard sb = new();
    bit long_hold_req = 0;
    int idle_cycles = 0;

    three_body_gravity_forces_top dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .body1_x(body1_x), .body1_y(body1_y), .body1_mass(body1_mass),
        .body2_x(body2_x), .body2_y(body2_y), .body2_mass(body2_mass),
        .body3_x(body3_x), .body3_y(body3_y), .body3_mass(body3_mass),
        .result_valid(result_valid), .result_stall(result_stall),
        .force1_x(force1_x), .force1_y(force1_y),
        .force2_x(force2_x), .force2_y(force2_y),
        .force3_x(force3_x), .force3_y(force3_y),
        .coincident_mask(coincident_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one request and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance so that a following
    // request can be placed at once with valid kept high.
    task automatic offer_request(input bodies_t b);
        item_valid <= 1'b1;
        body1_x <= b.x[0]; body1_y <= b.y[0]; body1_mass <= b.m[0];
        body2_x <= b.x[1]; body2_y <= b.y[1]; body2_mass <= b.m[1];
        body3_x <= b.x[2]; body3_y <= b.y[2]; body3_mass <= b.m[2];
        do
            @(posedge clk);
        while (item_stall);
        sb.note_request(b);
    endtask

    // Drop valid and idle for a number of cycles
    task automatic pause_sender(input int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Build a body set of a chosen shape: full random bits, clustered near
    // one point (realistic forces), with forced coincidences, or huge masses.
    function automatic bodies_t random_bodies();
        bodies_t b;
        int shape;
        logic [31:0] cx;
        logic [31:0] cy;
        shape = $urandom_range(0, 9);
        cx = $urandom();
        cy = $urandom();
        for (int i = 0; i < 3; i++)
        begin
            if (shape <= 1)
            begin
                b.x[i] = $urandom();
                b.y[i] = $urandom();
                b.m[i] = $urandom();
            end
            else
            begin
                // Spread within a window of random size around a center
                b.x[i] = cx + ($urandom() >> $urandom_range(4, 31));
                b.y[i] = cy + ($urandom() >> $urandom_range(4, 31));
                b.m[i] = $urandom() >> $urandom_range(0, 24);
            end
            if ($urandom_range(0, 15) == 0)
                b.m[i] = 32'd0;
        end
        if (shape == 8)
        begin
            // Land one body on another, or all three together
            int a;
            int c;
            a = $urandom_range(0, 2);
            c = (a + $urandom_range(1, 2)) % 3;
            b.x[c] = b.x[a];
            b.y[c] = b.y[a];
            if ($urandom_range(0, 3) == 0)
            begin
                b.x[3 - a - c] = b.x[a];
                b.y[3 - a - c] = b.y[a];
            end
        end
        if (shape == 9)
        begin
            // Heavy bodies close together push the sums into saturation
            for (int i = 0; i < 3; i++)
            begin
                b.m[i] = 32'hFFFF_0000 | $urandom();
                b.x[i] = cx + $urandom_range(0, 3);
                b.y[i] = cy + $urandom_range(0, 3);
            end
        end
        return b;
    endfunction

    function automatic bodies_t make_bodies(input logic [31:0] x1, input logic [31:0] y1,
                                            input logic [31:0] m1, input logic [31:0] x2,
                                            input logic [31:0] y2, input logic [31:0] m2,
                                            input logic [31:0] x3, input logic [31:0] y3,
                                            input logic [31:0] m3);
        bodies_t b;
        b.x = '{x1, x2, x3};
        b.y = '{y1, y2, y3};
        b.m = '{m1, m2, m3};
        return b;
    endfunction

    // Sender: reset, directed requests, then random bursts with gaps
    initial
    begin
        bodies_t dir [$];
        int burst;
        bit hold_done;
        bit drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        item_valid = 1'b0;
        body1_x = '0; body1_y = '0; body1_mass = '0;
        body2_x = '0; body2_y = '0; body2_mass = '0;
        body3_x = '0; body3_y = '0; body3_mass = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All coincident, all zero
        dir.push_back(make_bodies(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // All coincident with mass
        dir.push_back(make_bodies(5, 5, '1, 5, 5, '1, 5, 5, '1));
        // Each pair coincident alone
        dir.push_back(make_bodies(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h30000, 0, 32'h10000));
        dir.push_back(make_bodies(0, 0, 32'h10000, 0, 32'h20000, 32'h10000, 0, 0, 32'h10000));
        dir.push_back(make_bodies(32'h40000, 0, 32'h10000, 0, 7, 32'h20000, 0, 7, 32'h10000));
        // Unit bodies at unit spacing, a plain triangle
        dir.push_back(make_bodies(0, 0, 32'h10000, 32'h10000, 0, 32'h10000,
                                  0, 32'h10000, 32'h10000));
        // Extreme positions: widest separation in both axes
        dir.push_back(make_bodies(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 32'h8000_0000,
                                  32'h8000_0000, '1, 32'h8000_0000, 32'h7FFF_FFFF, '1));
        dir.push_back(make_bodies(32'h8000_0000, 0, 1, 32'h7FFF_FFFF, 0, 1, 0, 32'h8000_0000, 1));
        // Zero masses at distinct points: no flag, and no force from a pair with a massless body
        dir.push_back(make_bodies(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
        dir.push_back(make_bodies(0, 0, 0, 1, 0, '1, 2, 0, '1));
        // Huge masses one step apart: saturation both ways
        dir.push_back(make_bodies(0, 0, '1, 1, 0, '1, 0, 1, '1));
        dir.push_back(make_bodies(1, 1, '1, 0, 0, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
        // Smallest masses, tiny forces that truncate to zero
        dir.push_back(make_bodies(0, 0, 1, 32'h100_0000, 0, 1, 0, 32'h100_0000, 1));
        foreach (dir[i])
            offer_request(dir[i]);

        for (int n = 0; n < RANDOM_REQUESTS; )
        begin
            if (n >= 600 && !hold_done)
            begin
                // Hold off the receiver and keep offering so the pipe fills
                hold_done = 1'b1;
                long_hold_req = 1'b1;
            end
            if (n >= 1200 && !drain_done)
            begin
                // Pause until every expected result has come back
                drain_done = 1'b1;
                item_valid <= 1'b0;
                while (sb.pending_forces.size() != 0)
                    @(posedge clk);
            end
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++)
                offer_request(random_bodies());
            if ($urandom_range(0, 4) != 0)
                pause_sender($urandom_range(1, 8));
        end
        item_valid <= 1'b0;

        while (sb.pending_forces.size() != 0)
            @(posedge clk);
        repeat (tbg_pkg::LAT + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_forces.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: check each accepted result, choose the next stall, and
    // count cycles with no handshake on either side
    initial
    begin
        int hold_left;
        int mode;
        int phase;
        forces_t got;
        hold_left = 0;
        mode = 0;
        phase = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_valid && !result_stall)
                begin
                    got.fx = '{force1_x, force2_x, force3_x};
                    got.fy = '{force1_y, force2_y, force3_y};
                    got.mask = coincident_mask;
                    sb.check_result(got);
                end
                if ((result_valid && !result_stall) || (item_valid && !item_stall))
                    idle_cycles = 0;
                else
                    idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            // Advance the stall pattern: free flow, light, heavy, periodic
            phase++;
            if (phase % 97 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 9) < 3);
                    2: result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= (phase % 5 < 2);
                endcase
            end
        end
    end

endmodule
